### rtl/cdeq_pkg.sv
package cdeq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_TRAVERSE   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic               last;
    } rsp_t;

endpackage

### rtl/circular_double_ended_queue_unit.sv
// Push and pop: the request is accepted, then the ring is updated and the result is
// registered when the output register is free. Traverse: entries are read from the
// ring memory by a registered read, front to back, and emitted in S_TRAV_EMIT.
// A result sits in an output register, so the next request is taken while it waits.
// Reset (rst_n, asynchronous) empties the queue; ring contents are not cleared.
module circular_double_ended_queue_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  cdeq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output cdeq_pkg::rsp_t rsp
);
    import cdeq_pkg::*;

    localparam logic [1:0] S_IDLE      = 2'd0;
    localparam logic [1:0] S_EXEC      = 2'd1;
    localparam logic [1:0] S_TRAV_RD   = 2'd2;
    localparam logic [1:0] S_TRAV_EMIT = 2'd3;

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DEPTH - 1);
    localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    req_t             op_reg, op_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_reg, out_next;

    logic [31:0]      mem [DEPTH];
    logic [31:0]      rd_data_reg;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W:0]   rd_sum;
    logic [IDX_W:0]   back_sum;
    logic [IDX_W-1:0] back_slot;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] front_inc;
    logic             out_free;
    logic             is_full;
    logic             is_empty;
    logic             trav_last;

    assign is_full  = (count_reg == CNT_FULL);
    assign is_empty = (count_reg == '0);
    assign out_free = !out_valid_reg || rsp_ready;

    assign front_dec = (front_reg == '0) ? IDX_MAX : front_reg - 1'b1;
    assign front_inc = (front_reg == IDX_MAX) ? '0 : front_reg + 1'b1;

    // count is below DEPTH whenever a back push is taken
    assign back_sum  = {1'b0, front_reg} + {1'b0, count_reg[IDX_W-1:0]};
    assign back_slot = (back_sum >= DEPTH_X) ? IDX_W'(back_sum - DEPTH_X) : back_sum[IDX_W-1:0];

    assign rd_sum  = {1'b0, front_reg} + {1'b0, idx_reg};
    assign rd_addr = (rd_sum >= DEPTH_X) ? IDX_W'(rd_sum - DEPTH_X) : rd_sum[IDX_W-1:0];

    assign trav_last = ({1'b0, idx_reg} + 1'b1) == (IDX_W + 1)'(count_reg);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= op_reg.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        we             = 1'b0;
        waddr          = back_slot;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req;
                    idx_next   = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{data: '0, status: ST_OK, last: 1'b1};
                    state_next     = S_IDLE;
                    unique case (op_reg.func)
                        OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                out_next.status = ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = front_dec;
                                front_next = front_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                out_next.status = ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                out_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                front_next = front_inc;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                out_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_TRAVERSE:
                        begin
                            if (is_empty)
                            begin
                                out_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                // first entry is being read this cycle
                                out_valid_next = out_valid_reg && !rsp_ready;
                                out_next       = out_reg;
                                state_next     = S_TRAV_EMIT;
                            end
                        end
                        default:
                        begin
                            // unused codes: plain ok, nothing changes
                        end
                    endcase
                end
            end
            S_TRAV_RD:
            begin
                state_next = S_TRAV_EMIT;
            end
            S_TRAV_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = '{data: rd_data_reg, status: ST_OK, last: trav_last};
                    if (trav_last)
                    begin
                        idx_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_TRAV_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        out_reg <= out_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import cdeq_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 434;
    localparam int unsigned HOLD_AT = 150;
    localparam int unsigned HOLD_BURST = 40;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned PAUSE_AT = 300;
    localparam int unsigned CALM_ITEMS = 60;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned PRINT_LIMIT = 50;

    localparam int unsigned MODE_FILL = 0;
    localparam int unsigned MODE_DRAIN = 1;
    localparam int unsigned MODE_MIXED = 2;

    // func codes the block treats as no-ops
    localparam logic [2:0] SPARE_OPS [3] = '{3'd5, 3'd6, 3'd7};

    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    class deque_tracker;
        logic signed [31:0] shadow_slots [DEPTH];
        int unsigned        shadow_front;
        int unsigned        shadow_fill;
        rsp_t               pending_results [$];
        int unsigned        mismatch_count;

        task report_mismatch(string text);
            if (mismatch_count < PRINT_LIMIT)
            begin
                $display("ERROR %0t: %s", $time, text);
            end
            mismatch_count++;
        endtask

        // apply one accepted request to the shadow deque, queue what it must produce
        function void take_request(req_t r);
            rsp_t        single;
            int unsigned k;
            single.data = '0;
            single.status = ST_OK;
            single.last = 1'b1;
            case (r.func)
                OP_PUSH_FRONT, OP_PUSH_BACK:
                begin
                    if (shadow_fill == DEPTH)
                    begin
                        single.status = ST_FULL;
                    end
                    else
                    begin
                        if (r.func == OP_PUSH_FRONT)
                        begin
                            shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                            shadow_slots[shadow_front] = r.value;
                        end
                        else
                        begin
                            shadow_slots[(shadow_front + shadow_fill) % DEPTH] = r.value;
                        end
                        shadow_fill++;
                    end
                end
                OP_POP_FRONT, OP_POP_BACK:
                begin
                    if (shadow_fill == 0)
                    begin
                        single.status = ST_EMPTY;
                    end
                    else
                    begin
                        if (r.func == OP_POP_FRONT)
                        begin
                            shadow_front = (shadow_front + 1) % DEPTH;
                        end
                        shadow_fill--;
                    end
                end
                OP_TRAVERSE:
                begin
                    if (shadow_fill == 0)
                    begin
                        single.status = ST_EMPTY;
                    end
                    else
                    begin
                        for (k = 0; k < shadow_fill; k++)
                        begin
                            single.data = shadow_slots[(shadow_front + k) % DEPTH];
                            single.last = (k + 1 == shadow_fill);
                            pending_results.push_back(single);
                        end
                        return;
                    end
                end
                default:
                begin
                end
            endcase
            pending_results.push_back(single);
        endfunction

        task match_result(rsp_t got);
            rsp_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result data=%0d status=%0d last=%0b",
                                          got.data, got.status, got.last));
                return;
            end
            want = pending_results.pop_front();
            if (got.data !== want.data)
            begin
                report_mismatch($sformatf("data %0d, want %0d", got.data, want.data));
            end
            if (got.status !== want.status)
            begin
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            end
            if (got.last !== want.last)
            begin
                report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    bit calm = 1'b0;
    bit rx_idle_on = 1'b1;
    bit long_hold = 1'b0;

    deque_tracker tracker = new;

    circular_double_ended_queue_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // both channels sampled at the edge, before any of this edge's updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                tracker.take_request(req);
            end
            if (rsp_valid && rsp_ready)
            begin
                tracker.match_result(rsp);
            end
        end
    end

    function automatic logic [2:0] pick_op(int unsigned mode);
        int unsigned roll;
        int unsigned push_pct;
        roll = $urandom_range(0, 99);
        push_pct = (mode == MODE_FILL) ? 75 : (mode == MODE_DRAIN) ? 25 : 50;
        if (roll < 3)
        begin
            return SPARE_OPS[$urandom_range(0, 2)];
        end
        if (roll < 12)
        begin
            return OP_TRAVERSE;
        end
        if ($urandom_range(0, 99) < push_pct)
        begin
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end
        return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 11))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // returns at the edge where the transfer happens; valid is left high
    task automatic send_request(input logic [2:0] op, input logic signed [31:0] val);
        req_t r;
        r.func = op;
        r.value = val;
        req_valid <= 1'b1;
        req <= r;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
    endtask

    task automatic sender_gap(input int unsigned cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin : receiver
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            if ($urandom_range(0, 15) == 0)
            begin
                rx_idle_on = !rx_idle_on;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned sent;
        int unsigned span;
        int unsigned mode;
        int unsigned k;
        int unsigned i;
        bit          tx_idle_on;
        bit          burst;
        sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, spare codes
        send_request(OP_TRAVERSE, pick_value());
        send_request(OP_POP_FRONT, pick_value());
        send_request(OP_POP_BACK, pick_value());
        send_request(SPARE_OPS[0], pick_value());
        send_request(SPARE_OPS[2], pick_value());

        // fill to the brim from both ends, push into a full store, then traverse and pop
        send_request(OP_PUSH_FRONT, VAL_MAX);
        send_request(OP_PUSH_BACK, VAL_MIN);
        for (i = 0; i < DEPTH - 2; i++)
        begin
            send_request(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
                         (i == 0) ? 32'sd0 : (i == 1) ? -32'sd1 : $urandom);
        end
        send_request(OP_PUSH_FRONT, pick_value());
        send_request(OP_PUSH_BACK, pick_value());
        send_request(OP_TRAVERSE, pick_value());
        send_request(OP_POP_FRONT, pick_value());
        send_request(OP_POP_BACK, pick_value());
        send_request(OP_TRAVERSE, pick_value());
        wait_drained();

        while (sent < RANDOM_ITEMS)
        begin
            mode = $urandom_range(MODE_FILL, MODE_MIXED);
            span = $urandom_range(8, 40);
            tx_idle_on = ($urandom_range(0, 2) != 0);
            for (k = 0; k < span && sent < RANDOM_ITEMS; k++)
            begin
                calm = (sent + CALM_ITEMS >= RANDOM_ITEMS);
                if (sent == HOLD_AT)
                begin
                    long_hold = 1'b1;
                end
                if (sent == PAUSE_AT)
                begin
                    wait_drained();
                end
                burst = (sent >= HOLD_AT && sent < HOLD_AT + HOLD_BURST);
                send_request(pick_op(mode), pick_value());
                sent++;
                if (!calm && !burst && tx_idle_on && $urandom_range(0, 4) == 0)
                begin
                    sender_gap($urandom_range(1, 18));
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (tracker.mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
rtl/cdeq_pkg.sv
rtl/circular_double_ended_queue_unit.sv
sim/testbench.sv
